// ===== hw/rtl/rpnp_pkg.sv =====
// ----------------------------------------------------------------------------
// rpnp_pkg: shared types and constants of the multi-radix number parser
// transaction payloads, parser state, status codes and the digit decoder
// ----------------------------------------------------------------------------
`default_nettype none

package rpnp_pkg;

    localparam int VALUE_WIDTH = 64;    // accumulator width, 8 to 64
    localparam int OUT_WIDTH   = 64;

    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_O     = 8'h6f;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_F     = 8'h66;

    typedef enum logic [1:0] {
        PH_START  = 2'd0,
        PH_RADIX  = 2'd1,
        PH_DIGITS = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        RX_DEC = 2'd0,
        RX_BIN = 2'd1,
        RX_OCT = 2'd2,
        RX_HEX = 2'd3
    } radix_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RADIX = 2'd1,
        ST_DIGIT = 2'd2
    } status_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } char_t;

    typedef struct packed {
        logic signed [OUT_WIDTH-1:0] value;
        logic [1:0]                  status;
    } result_t;

    typedef struct packed {
        phase_t                 phase;
        logic                   negative;
        radix_t                 radix;
        logic [VALUE_WIDTH-1:0] acc;
        status_t                err;
    } parse_state_t;

    localparam parse_state_t STATE_INIT = '{
        phase:    PH_START,
        negative: 1'b0,
        radix:    RX_DEC,
        acc:      '0,
        err:      ST_OK
    };

    // {valid, digit value} of a character in the given radix
    function automatic logic [4:0] digit_of(input logic [7:0] c, input radix_t rx);
        logic [4:0] d;
        logic [7:0] off;
        d   = '0;
        off = '0;
        if (c >= CH_0 && c <= CH_9)
        begin
            off = c - CH_0;
            d   = {1'b1, off[3:0]};
        end
        else if (c >= CH_A && c <= CH_F)
        begin
            off = c - CH_A + 8'd10;
            d   = {1'b1, off[3:0]};
        end
        case (rx)
            RX_BIN:  if (d[3:0] >= 4'd2)  d[4] = 1'b0;
            RX_OCT:  if (d[3:0] >= 4'd8)  d[4] = 1'b0;
            RX_HEX:  d = d;
            default: if (d[3:0] >= 4'd10) d[4] = 1'b0;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/rpnp_step.sv =====
// ----------------------------------------------------------------------------
// rpnp_step: one character of parsing
// next parser state and the result of a string's final character
// ----------------------------------------------------------------------------
`default_nettype none

module rpnp_step
    import rpnp_pkg::*;
(
    input  wire parse_state_t cur,
    input  wire char_t        char_in,
    output parse_state_t      nxt,
    output result_t           res
);

    logic                   take_radix;
    logic [4:0]             dig;
    logic [VALUE_WIDTH-1:0] scaled;
    logic [VALUE_WIDTH-1:0] mag;
    status_t                st;

    assign take_radix = (cur.phase == PH_START && char_in.ch != CH_MINUS)
                     || (cur.phase == PH_RADIX);
    assign dig = digit_of(char_in.ch, cur.radix);

    // constant-radix multiply as shifts and adds
    always_comb
    begin
        case (cur.radix)
            RX_BIN:  scaled = cur.acc << 1;
            RX_OCT:  scaled = cur.acc << 3;
            RX_HEX:  scaled = cur.acc << 4;
            default: scaled = (cur.acc << 3) + (cur.acc << 1);
        endcase
    end

    always_comb
    begin
        nxt = cur;
        if (cur.phase == PH_START && char_in.ch == CH_MINUS)
        begin
            nxt.negative = 1'b1;
            nxt.phase    = PH_RADIX;
        end
        else if (take_radix)
        begin
            nxt.phase = PH_DIGITS;
            case (char_in.ch)
                CH_D:    nxt.radix = RX_DEC;
                CH_B:    nxt.radix = RX_BIN;
                CH_O:    nxt.radix = RX_OCT;
                CH_X:    nxt.radix = RX_HEX;
                default: if (cur.err == ST_OK) nxt.err = ST_RADIX;
            endcase
        end
        else if (dig[4])
        begin
            nxt.acc = scaled + VALUE_WIDTH'(dig[3:0]);
        end
        else if (cur.err == ST_OK)
        begin
            nxt.err = ST_DIGIT;
        end

        // string ended before any radix letter
        st = nxt.err;
        if (nxt.phase != PH_DIGITS && st == ST_OK)
            st = ST_RADIX;

        mag = nxt.negative ? (~nxt.acc + VALUE_WIDTH'(1)) : nxt.acc;
        res.status = st;
        if (st != ST_OK)
            res.value = '0;
        else
            res.value = OUT_WIDTH'($signed(mag));

        if (char_in.last)
            nxt = STATE_INIT;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/radix_prefixed_number_parser_core.sv =====
// a final character is held in the input register, and its result is then written to the result register
// throughput: one character per cycle from the accumulate step, but a final character waits while a result is held
// the input register frees while a finished result waits at the output register
// reset: rst_n (async, active low) empties both registers and starts a new string
// ----------------------------------------------------------------------------
// radix_prefixed_number_parser_core: ascii multi-radix integer parser
// input register, one parse step, result register
// ----------------------------------------------------------------------------
`default_nettype none

module radix_prefixed_number_parser_core
    import rpnp_pkg::*;
(
    input  wire          clk,
    input  wire          rst_n,
    input  wire          char_valid,
    output logic         char_ready,
    input  wire char_t   char_data,
    output logic         result_valid,
    input  wire          result_ready,
    output result_t      result_data
);

    logic         in_valid_reg;
    char_t        in_data_reg;
    parse_state_t state_reg;
    parse_state_t state_next;
    result_t      result_next;
    result_t      result_data_reg;
    logic         result_valid_reg;
    logic         advance;

    // only a final character has to wait for a free result register
    assign advance    = in_valid_reg
                     && (!in_data_reg.last || !result_valid_reg || result_ready);
    assign char_ready = !in_valid_reg || advance;

    rpnp_step u_step (
        .cur     (state_reg),
        .char_in (in_data_reg),
        .nxt     (state_next),
        .res     (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
            state_reg        <= STATE_INIT;
        end
        else
        begin
            if (char_ready)
                in_valid_reg <= char_valid;
            if (advance && in_data_reg.last)
                result_valid_reg <= 1'b1;
            else if (result_valid_reg && result_ready)
                result_valid_reg <= 1'b0;
            if (advance)
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_ready && char_valid)
            in_data_reg <= char_data;
        if (advance && in_data_reg.last)
            result_data_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result_data  = result_data_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/rpnp_checker.sv =====
// ----------------------------------------------------------------------------
// rpnp_checker: port-level checks of the number parser
// bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module rpnp_checker
    import rpnp_pkg::*;
(
    input wire          clk,
    input wire          rst_n,
    input wire          char_valid,
    input wire          char_ready,
    input wire char_t   char_data,
    input wire          result_valid,
    input wire          result_ready,
    input wire result_t result_data
);

    // a stalled input transaction holds
    a_char_hold: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && !char_ready |=> char_valid && $stable(char_data))
        else $error("input changed while stalled");

    // a stalled result transaction holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_data))
        else $error("result changed while stalled");

    // an error result carries a zero value
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_data.status != ST_OK |-> result_data.value == '0)
        else $error("error result with nonzero value");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result_data.status == ST_OK || result_data.status == ST_RADIX
                          || result_data.status == ST_DIGIT))
        else $error("unused status code");

    // with the output empty the input side never stalls
    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> char_ready)
        else $error("input stalled with empty output");

endmodule

bind radix_prefixed_number_parser_core rpnp_checker u_rpnp_checker (.*);

`default_nettype wire

// ===== tb/radix_prefixed_number_parser_checker.sv =====
// ----------------------------------------------------------------------------
// radix_prefixed_number_parser_checker: result scoreboard for the number parser
// watches both channels, runs its own parse of every accepted character and
// compares each accepted result field by field with the oldest prediction
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module radix_prefixed_number_parser_checker
    import rpnp_pkg::*;
(
    input  wire     clk,
    input  wire     rst_n,
    input  wire     char_valid,
    input  wire     char_ready,
    input  char_t   char_data,
    input  wire     result_valid,
    input  wire     result_ready,
    input  result_t result_data,
    output int      fail_count,
    output int      pending
);

    localparam int SHOWN_MAX = 10;

    phase_t                 ph;
    logic                   neg;
    radix_t                 rx;
    logic [VALUE_WIDTH-1:0] acc;
    status_t                err;

    result_t expected_results[$];
    int      reported;

    initial
    begin
        fail_count = 0;
        reported   = 0;
        pending    = 0;
    end

    function automatic int radix_base(input radix_t r);
        case (r)
            RX_BIN:  return 2;
            RX_OCT:  return 8;
            RX_HEX:  return 16;
            default: return 10;
        endcase
    endfunction

    // weight of a character as a digit, -1 when it is no digit in any radix
    function automatic int char_weight(input logic [7:0] c);
        if (c >= CH_0 && c <= CH_9)
            return int'(c - CH_0);
        if (c >= CH_A && c <= CH_F)
            return int'(c - CH_A) + 10;
        return -1;
    endfunction

    task automatic clear_parse();
        ph  = PH_START;
        neg = 1'b0;
        rx  = RX_DEC;
        acc = '0;
        err = ST_OK;
    endtask

    task automatic take_radix_letter(input logic [7:0] c);
        ph = PH_DIGITS;
        case (c)
            CH_D:    rx = RX_DEC;
            CH_B:    rx = RX_BIN;
            CH_O:    rx = RX_OCT;
            CH_X:    rx = RX_HEX;
            default: if (err == ST_OK) err = ST_RADIX;
        endcase
    endtask

    task automatic parse_char(input char_t item);
        int                            w;
        status_t                       st;
        logic [VALUE_WIDTH-1:0]        mag;
        logic signed [VALUE_WIDTH-1:0] smag;
        result_t                       r;
        w = char_weight(item.ch);
        case (ph)
            PH_START:
            begin
                if (item.ch == CH_MINUS)
                begin
                    neg = 1'b1;
                    ph  = PH_RADIX;
                end
                else
                    take_radix_letter(item.ch);
            end
            PH_RADIX:
                take_radix_letter(item.ch);
            default:
            begin
                if (w < 0 || w >= radix_base(rx))
                begin
                    if (err == ST_OK)
                        err = ST_DIGIT;
                end
                else
                    acc = acc * VALUE_WIDTH'(radix_base(rx)) + VALUE_WIDTH'(w);
            end
        endcase
        if (item.last)
        begin
            st = err;
            // string ended while a radix letter was still due
            if (ph != PH_DIGITS && st == ST_OK)
                st = ST_RADIX;
            r.status = st;
            r.value  = '0;
            if (st == ST_OK)
            begin
                mag     = neg ? (~acc + 1'b1) : acc;
                smag    = mag;
                r.value = smag;
            end
            expected_results.push_back(r);
            clear_parse();
        end
    endtask

    task automatic check_result(input result_t got);
        result_t want;
        if (expected_results.size() == 0)
        begin
            fail_count++;
            if (reported < SHOWN_MAX)
            begin
                reported++;
                $display("unexpected result: value %0d status %0d", got.value, got.status);
            end
        end
        else
        begin
            want = expected_results.pop_front();
            if (got.value !== want.value || got.status !== want.status)
            begin
                fail_count++;
                if (reported < SHOWN_MAX)
                begin
                    reported++;
                    $display("result mismatch: expected value %0d status %0d, got value %0d status %0d",
                             want.value, want.status, got.value, got.status);
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_parse();
            expected_results.delete();
            pending = 0;
        end
        else
        begin
            if (char_valid && char_ready)
                parse_char(char_data);
            if (result_valid && result_ready)
                check_result(result_data);
            pending = expected_results.size();
        end
    end

endmodule

// ===== tb/radix_prefixed_number_parser_core_tb.sv =====
// ----------------------------------------------------------------------------
// radix_prefixed_number_parser_core_tb: top level test of the number parser
// directed strings for signs, radix letters, bad characters and empty digit
// runs, then random strings under three idle patterns on both channels
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module radix_prefixed_number_parser_core_tb;
    import rpnp_pkg::*;

    localparam int ITEMS_PER_PHASE = 560;
    localparam int STALL_LIMIT     = 2000;
    localparam int SETTLE_CYCLES   = 10;

    logic    clk          = 1'b0;
    logic    rst_n        = 1'b0;
    logic    char_valid   = 1'b0;
    char_t   char_data    = '0;
    logic    result_ready = 1'b0;
    logic    char_ready;
    logic    result_valid;
    result_t result_data;

    int fail_count;
    int pending;
    int chars_sent   = 0;
    int tx_idle_pct  = 19;
    int rx_idle_pct  = 48;
    int stall_cycles = 0;

    logic [7:0] text[$];
    int         base_of[4] = '{10, 2, 8, 16};

    radix_prefixed_number_parser_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_valid   (char_valid),
        .char_ready   (char_ready),
        .char_data    (char_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data)
    );

    radix_prefixed_number_parser_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_valid   (char_valid),
        .char_ready   (char_ready),
        .char_data    (char_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    always #10 clk = ~clk;

    always @(negedge clk)
        result_ready = ($urandom_range(99) >= rx_idle_pct);

    // no transaction on either channel for too long means the block hung
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((char_valid && char_ready) || (result_valid && result_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_char(input logic [7:0] c, input logic l);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            char_valid = 1'b0;
            @(negedge clk);
        end
        char_valid     = 1'b1;
        char_data.ch   = c;
        char_data.last = l;
        @(posedge clk);
        while (!char_ready)
            @(posedge clk);
        @(negedge clk);
        chars_sent++;
    endtask

    task automatic send_str(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], i == s.len() - 1);
    endtask

    task automatic send_text();
        for (int i = 0; i < text.size(); i++)
            send_char(text[i], i == text.size() - 1);
    endtask

    task automatic build_well_formed(input bit need_digits);
        radix_t r;
        int     base;
        int     n;
        int     sel;
        int     mode;
        int     d;
        text.delete();
        if ($urandom_range(1))
            text.push_back(CH_MINUS);
        r    = radix_t'($urandom_range(3));
        base = base_of[r];
        case (r)
            RX_DEC:  text.push_back(CH_D);
            RX_BIN:  text.push_back(CH_B);
            RX_OCT:  text.push_back(CH_O);
            default: text.push_back(CH_X);
        endcase
        sel = $urandom_range(9);
        if (sel < 6)
            n = $urandom_range(6);
        else if (sel < 8)
            n = $urandom_range(20, 7);
        else
            n = $urandom_range(66, 21);
        mode = $urandom_range(9);
        // top digit only, sized to land on the sign bit for hex and binary
        if (mode == 9 && r == RX_HEX)
            n = 16;
        else if (mode == 9 && r == RX_BIN)
            n = 64;
        if (need_digits && n == 0)
            n = 1;
        for (int i = 0; i < n; i++)
        begin
            if (mode < 7)
                d = $urandom_range(base - 1);
            else if (mode < 9)
                d = base - 1;
            else
                d = (i == 0) ? base / 2 : 0;
            text.push_back(d < 10 ? CH_0 + 8'(d) : CH_A + 8'(d - 10));
        end
    endtask

    task automatic random_string();
        int roll;
        int n;
        roll = $urandom_range(99);
        if (roll < 80)
            build_well_formed(1'b0);
        else if (roll < 92)
        begin
            build_well_formed(1'b1);
            text[$urandom_range(text.size() - 1)] = 8'($urandom_range(255));
        end
        else
        begin
            text.delete();
            n = $urandom_range(6, 1);
            for (int i = 0; i < n; i++)
                text.push_back(8'($urandom_range(255)));
        end
    endtask

    task automatic run_random(input int target);
        while (chars_sent < target)
        begin
            random_string();
            send_text();
        end
    endtask

    initial
    begin
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // lone minus, missing digits, each radix, bad digits and bad radix letters
        send_str("-");
        send_str("d");
        send_str("-d");
        send_str("-d9");
        send_str("b12");
        send_str("o8");
        send_str("xaf");
        send_char(8'h00, 1'b1);
        send_str("--");
        send_char(CH_D, 1'b0);
        send_char(8'hff, 1'b1);
        send_str("xA");
        send_str("-b1");

        run_random(ITEMS_PER_PHASE);
        tx_idle_pct = 48;
        rx_idle_pct = 19;
        run_random(2 * ITEMS_PER_PHASE);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_random(3 * ITEMS_PER_PHASE);
        char_valid = 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (fail_count == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/rpnp_pkg.sv
hw/rtl/rpnp_step.sv
hw/rtl/radix_prefixed_number_parser_core.sv
hw/rtl/rpnp_checker.sv
tb/radix_prefixed_number_parser_checker.sv
tb/radix_prefixed_number_parser_core_tb.sv
